### sv/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// shared sizes, coefficient table and control structs of the 4x true-peak
// detector
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int TAPS      = 12;
  localparam int PHASES    = 4;
  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 14;
  localparam int FRAC_BITS = 13;
  localparam int PEAK_W    = 25;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + $clog2(TAPS);
  localparam int TAP_W     = $clog2(TAPS);
  localparam int PH_W      = $clog2(PHASES);

  // polyphase coefficients in units of 2^-13, row per phase, column per tap
  localparam logic signed [COEF_W-1:0] COEF_TAB [PHASES][TAPS] = '{
    '{  14'sd14,    14'sd90,   -14'sd161,  14'sd272,  -14'sd487,  14'sd1125,
        14'sd7964, -14'sd838,   14'sd390, -14'sd218,   14'sd122, -14'sd68 },
    '{ -14'sd239,   14'sd240,  -14'sd424,  14'sd730, -14'sd1364,  14'sd3810,
        14'sd6388, -14'sd1641,  14'sd832, -14'sd477,   14'sd271, -14'sd155 },
    '{ -14'sd155,   14'sd271,  -14'sd477,  14'sd832, -14'sd1641,  14'sd6388,
        14'sd3810, -14'sd1364,  14'sd730, -14'sd424,   14'sd240, -14'sd239 },
    '{ -14'sd68,    14'sd122,  -14'sd218,  14'sd390,  -14'sd838,  14'sd7964,
        14'sd1125, -14'sd487,   14'sd272, -14'sd161,   14'sd90,   14'sd14 }
  };

  // control shared by every delay cell
  typedef struct packed {
    logic clear;
    logic load;
    logic rotate;
  } tpd_cell_ctl_t;

  // one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tpd_issue_t;

endpackage

### sv/tpd_tap_cell.sv
// ----------------------------------------------------------------------------
// tpd_tap_cell
// one delay-line cell: shifts in from the left on a new sample, rotates in
// from the right while the filter phases are being walked
// ----------------------------------------------------------------------------
module tpd_tap_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tpd_pkg::tpd_cell_ctl_t                ctl_i,
  input  logic signed [tpd_pkg::SAMPLE_W-1:0]   left_i,
  input  logic signed [tpd_pkg::SAMPLE_W-1:0]   right_i,
  output logic signed [tpd_pkg::SAMPLE_W-1:0]   q_o
);
  import tpd_pkg::*;

  logic signed [SAMPLE_W-1:0] q_r;
  logic signed [SAMPLE_W-1:0] q_nxt;

  always_comb begin
    priority if (ctl_i.clear) begin
      q_nxt = '0;
    end else if (ctl_i.load) begin
      q_nxt = left_i;
    end else if (ctl_i.rotate) begin
      q_nxt = right_i;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

### sv/tpd_mac.sv
// ----------------------------------------------------------------------------
// tpd_mac
// registered multiply, exact accumulate over one phase, then magnitude
// scaled down by 2^13 with saturation
// ----------------------------------------------------------------------------
module tpd_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tpd_pkg::tpd_issue_t                   issue_i,
  input  logic signed [tpd_pkg::SAMPLE_W-1:0]   x_i,
  input  logic signed [tpd_pkg::COEF_W-1:0]     coef_i,
  output logic [tpd_pkg::PEAK_W-1:0]            mag_o,
  output logic                                  mag_valid_o,
  output logic                                  busy_o
);
  import tpd_pkg::*;

  localparam int SH_W = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  tpd_issue_t               prod_ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     acc_done_r;
  logic [ACC_W-1:0]         acc_abs;
  logic [SH_W-1:0]          acc_sh;
  logic [PEAK_W-1:0]        mag_r;
  logic [PEAK_W-1:0]        mag_nxt;
  logic                     mag_valid_r;

  assign prod_nxt = PROD_W'(x_i) * PROD_W'(coef_i);

  assign acc_nxt = prod_ctl_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  // magnitude, truncating shift, clamp to the output range
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign acc_sh  = acc_abs[ACC_W-1:FRAC_BITS];
  assign mag_nxt = (|acc_sh[SH_W-1:PEAK_W]) ? {PEAK_W{1'b1}} : acc_sh[PEAK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ctl_r  <= '0;
      acc_done_r  <= 1'b0;
      mag_valid_r <= 1'b0;
    end else begin
      prod_ctl_r  <= issue_i;
      acc_done_r  <= prod_ctl_r.valid & prod_ctl_r.last;
      mag_valid_r <= acc_done_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (prod_ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (acc_done_r) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag_o       = mag_r;
  assign mag_valid_o = mag_valid_r;
  assign busy_o      = prod_ctl_r.valid | acc_done_r | mag_valid_r;

endmodule

### sv/true_peak_detector_4x_unit.sv
// ----------------------------------------------------------------------------
// true_peak_detector_4x_unit
// 4x oversampling true-peak meter: 12-tap delay line as a ring of cells,
// four polyphase fir phases walked through one shared multiply-accumulate
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser
//  --------+-----+-------------------------------+-------------------------
//  in_     | in  | [23:0] sample (signed)        | [0] mode, 1 = clear
//  out_    | out | [24:0] sample_peak,           | -
//          |     | [49:25] held_peak             |
//
//  a sample transfer is followed by one multiply-accumulate per tap and phase
//  on a single multiplier, then the three-stage product/accumulate/magnitude
//  drain until the pipe reads idle, then the publish step, before the next
//  input transfer is taken
//  a clear transfer is accepted, then publishes zeros
//  reset clears the delay cells, the held peak and all handshake state
//  a stalled output holds its result; the block waits in the publish step
//  until the output register is free
//
module true_peak_detector_4x_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [23:0] sample
  input  logic        in_tuser,    // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata    // [24:0] sample_peak, [49:25] held_peak, rest zero
);
  import tpd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam int OUT_W = 56;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  logic [TAP_W-1:0]    tap_r;
  logic [TAP_W-1:0]    tap_nxt;
  logic [PH_W-1:0]     phase_r;
  logic [PH_W-1:0]     phase_nxt;
  logic [PEAK_W-1:0]   best_r;
  logic [PEAK_W-1:0]   peak_hold_r;
  logic [PEAK_W-1:0]   held_new;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                in_xfer;
  logic                clear_req;
  logic                load_req;
  logic                fin_go;
  logic                tap_end;
  logic                phase_end;

  tpd_cell_ctl_t              cell_ctl;
  tpd_issue_t                 issue;
  logic signed [SAMPLE_W-1:0] cell_q [TAPS];
  logic [PEAK_W-1:0]          mag;
  logic                       mag_valid;
  logic                       mac_busy;

  // ---------------------------------------------------------------- control
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign clear_req = in_xfer & in_tuser;
  assign load_req  = in_xfer & ~in_tuser;
  assign fin_go    = (state_r == S_FIN) & (~out_valid_r | out_tready);
  assign tap_end   = (tap_r == TAP_W'(TAPS - 1));
  assign phase_end = (phase_r == PH_W'(PHASES - 1));

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        tap_nxt   = '0;
        phase_nxt = '0;
        if (load_req) begin
          state_nxt = S_RUN;
        end else if (clear_req) begin
          state_nxt = S_FIN;
        end
      end
      S_RUN: begin
        // tap counter walks the ring, phase counter steps once per turn
        if (tap_end) begin
          tap_nxt   = '0;
          phase_nxt = phase_r + PH_W'(1);
          if (phase_end) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          tap_nxt = tap_r + TAP_W'(1);
        end
      end
      S_DRAIN: begin
        // wait for the last phase magnitude to reach the running max
        if (!mac_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      phase_r <= phase_nxt;
    end
  end

  // ------------------------------------------------------- delay-line ring
  // cell 0 takes the new sample; while running the ring turns one place a
  // cycle so cell 0 presents tap 0, 1, 2 ... and is back home after a turn
  assign cell_ctl.clear  = clear_req;
  assign cell_ctl.load   = load_req;
  assign cell_ctl.rotate = (state_r == S_RUN);

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == TAPS - 1) ? 0 : i + 1;
    logic signed [SAMPLE_W-1:0] left_d;

    if (i == 0) begin : g_head
      assign left_d = $signed(in_tdata[SAMPLE_W-1:0]);
    end else begin : g_body
      assign left_d = cell_q[LEFT];
    end

    tpd_tap_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (cell_ctl),
      .left_i  (left_d),
      .right_i (cell_q[RIGHT]),
      .q_o     (cell_q[i])
    );
  end

  // --------------------------------------------------- multiply-accumulate
  assign issue.valid = (state_r == S_RUN);
  assign issue.first = (tap_r == '0);
  assign issue.last  = tap_end;

  tpd_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_i     (issue),
    .x_i         (cell_q[0]),
    .coef_i      (COEF_TAB[phase_r][tap_r]),
    .mag_o       (mag),
    .mag_valid_o (mag_valid),
    .busy_o      (mac_busy)
  );

  // ------------------------------------------------------ peak tracking
  assign held_new = (best_r > peak_hold_r) ? best_r : peak_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      peak_hold_r <= '0;
    end else begin
      if (in_xfer) begin
        best_r <= '0;
      end else if (mag_valid && (mag > best_r)) begin
        best_r <= mag;
      end
      if (clear_req) begin
        peak_hold_r <= '0;
      end else if (fin_go) begin
        peak_hold_r <= held_new;
      end
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= {(OUT_W - 2 * PEAK_W)'(0), held_new, best_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ------------------------------------------------------------ assertions
  // a sample transfer starts the walk at phase 0, tap 0
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=>
      (state_r == S_RUN) && (tap_r == '0) && (phase_r == '0))
    else $error("walk did not start at phase 0 tap 0");

  // nothing may still be in the multiply-accumulate pipe when publishing
  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !mac_busy)
    else $error("result published before pipe drained");

  // held peak never below the peak it was built from
  a_held_ge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*PEAK_W-1:PEAK_W] >= out_tdata[PEAK_W-1:0]))
    else $error("held peak below sample peak");

  // a clear empties the newest cell, the running peak and the held peak
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=>
      (cell_q[0] == '0) && (peak_hold_r == '0) && (best_r == '0))
    else $error("clear left state behind");

endmodule
